FILE: design/rau_pkg.sv
`default_nettype none
package rau_pkg;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int FIELD_BITS = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_GCD_CHK,
        ST_GCD_DIV,
        ST_RED_NUM,
        ST_RED_DEN,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic [1:0] mul_sel;
        logic sum;
        logic div_start;
        logic [1:0] div_mode;
        logic gcd_swap;
        logic red_num;
        logic red_den;
        logic out_load;
    } t_cmd;

    localparam logic [1:0] DM_GCD = 2'd0;
    localparam logic [1:0] DM_NUM = 2'd1;
    localparam logic [1:0] DM_DEN = 2'd2;

    // datapath -> controller
    typedef struct packed {
        logic b_zero;
        logic a_zero;
        logic div_busy;
        logic is_addsub;
    } t_sts;
endpackage
`default_nettype wire

FILE: design/rau_divider.sv
`default_nettype none
module rau_divider #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    output logic                      o_busy,
    output logic [WORD_BITS-1:0]      o_quo,
    output logic [WORD_BITS-1:0]      o_rem
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_q, n_q, r_r, n_r, r_d, r_ma;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_na, r_nq;
    logic [WORD_BITS:0]   w_sh, w_diff;
    logic [WORD_BITS-1:0] w_ma, w_mb;

    assign w_ma = i_a[WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb = i_b[WORD_BITS-1] ? (~i_b + 1'b1) : i_b;
    assign w_sh = {r_r, r_ma[WORD_BITS-1]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_comb begin
        if (!w_diff[WORD_BITS]) begin
            n_r = w_diff[WORD_BITS-1:0];
            n_q = {r_q[WORD_BITS-2:0], 1'b1};
        end else begin
            n_r = w_sh[WORD_BITS-1:0];
            n_q = {r_q[WORD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WORD_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma <= w_ma;
            r_d  <= w_mb;
            r_r  <= '0;
            r_q  <= '0;
            r_na <= i_a[WORD_BITS-1];
            r_nq <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        end else if (r_busy) begin
            r_ma <= {r_ma[WORD_BITS-2:0], 1'b0};
            r_r  <= n_r;
            r_q  <= n_q;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_nq ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_na ? (~r_r + 1'b1) : r_r;
endmodule
`default_nettype wire

FILE: design/rau_datapath.sv
`default_nettype none
module rau_datapath #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rau_pkg::t_cmd        i_cmd,
    input  wire logic [1:0]           i_op,
    input  wire logic [31:0]          i_ln,
    input  wire logic [31:0]          i_ld,
    input  wire logic [31:0]          i_rn,
    input  wire logic [31:0]          i_rd,
    output rau_pkg::t_sts             o_sts,
    output logic [31:0]               o_num,
    output logic [31:0]               o_den,
    output logic                      o_zero
);
    localparam int W = WORD_BITS;

    logic [1:0]   r_op;
    logic [W-1:0] r_ln, r_ld, r_rn, r_rd;
    logic [W-1:0] r_q, r_num, r_den, r_a, r_b;
    logic [W-1:0] w_x, w_y, w_prod, w_dva, w_dvb, w_quo, w_rem;
    logic [2*W-1:0] w_full;
    logic [31:0]  r_onum, r_oden;
    logic         r_oz;
    logic         w_busy;

    function automatic logic [W-1:0] fr(input logic [31:0] v);
        logic [63:0] e;
        e = {{32{v[31]}}, v};
        return e[W-1:0];
    endfunction

    function automatic logic [31:0] tf(input logic [W-1:0] v);
        logic [63:0] e;
        e = {64{v[W-1]}};
        e[W-1:0] = v;
        return e[31:0];
    endfunction

    // operand pair per multiply slot
    always_comb begin
        case (i_cmd.mul_sel)
            2'd0: begin
                w_x = r_ln;
                w_y = (r_op == rau_pkg::OP_MUL) ? r_rn : r_rd;
            end
            2'd1: begin
                w_x = r_ld;
                w_y = r_rd;
            end
            2'd2: begin
                w_x = r_ld;
                w_y = (r_op == rau_pkg::OP_DIV) ? r_rn : r_rd;
            end
            default: begin
                w_x = r_rn;
                w_y = r_ld;
            end
        endcase
    end
    assign w_full = w_x * w_y;
    assign w_prod = w_full[W-1:0];

    always_comb begin
        case (i_cmd.div_mode)
            rau_pkg::DM_NUM: begin
                w_dva = r_num;
                w_dvb = r_a;
            end
            rau_pkg::DM_DEN: begin
                w_dva = r_den;
                w_dvb = r_a;
            end
            default: begin
                w_dva = r_a;
                w_dvb = r_b;
            end
        endcase
    end

    rau_divider #(.WORD_BITS(W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_a    (w_dva),
        .i_b    (w_dvb),
        .o_busy (w_busy),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_ln <= fr(i_ln);
            r_ld <= fr(i_ld);
            r_rn <= fr(i_rn);
            r_rd <= fr(i_rd);
        end
        if (i_cmd.mul_step) begin
            case (i_cmd.mul_sel)
                2'd0:    r_num <= w_prod;
                2'd2:    r_den <= w_prod;
                default: r_q   <= w_prod;
            endcase
        end
        if (i_cmd.sum) begin
            r_num <= (r_op == rau_pkg::OP_ADD) ? (r_num + r_q) : (r_num - r_q);
            r_a   <= (r_op == rau_pkg::OP_ADD) ? (r_num + r_q) : (r_num - r_q);
            r_b   <= r_den;
        end
        if (i_cmd.gcd_swap) begin
            r_a <= r_b;
            r_b <= w_rem;
        end
        if (i_cmd.red_num) begin
            r_num <= w_quo;
        end
        if (i_cmd.red_den) begin
            r_den <= w_quo;
        end
        if (i_cmd.out_load) begin
            r_onum <= tf(r_num);
            r_oden <= tf(r_den);
            r_oz   <= (r_den == '0);
        end
    end

    assign o_sts.b_zero    = (r_b == '0);
    assign o_sts.a_zero    = (r_a == '0);
    assign o_sts.div_busy  = w_busy;
    assign o_sts.is_addsub = ~r_op[1];
    assign o_num  = r_onum;
    assign o_den  = r_oden;
    assign o_zero = r_oz;
endmodule
`default_nettype wire

FILE: design/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd      o_cmd
);
    rau_pkg::t_state r_state, n_state;
    logic r_ov, n_ov;
    logic w_free;

    // the output word may wait while the next item is worked on
    assign w_free = !r_ov || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE:    if (i_in_valid) n_state = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1:    n_state = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:    n_state = i_sts.is_addsub ? rau_pkg::ST_MUL3
                                                           : rau_pkg::ST_DONE;
            rau_pkg::ST_MUL3:    n_state = rau_pkg::ST_SUM;
            rau_pkg::ST_SUM:     n_state = rau_pkg::ST_GCD_CHK;
            rau_pkg::ST_GCD_CHK: begin
                if (i_sts.b_zero) begin
                    n_state = i_sts.a_zero ? rau_pkg::ST_DONE : rau_pkg::ST_RED_NUM;
                end else begin
                    n_state = rau_pkg::ST_GCD_DIV;
                end
            end
            rau_pkg::ST_GCD_DIV: if (!i_sts.div_busy) n_state = rau_pkg::ST_GCD_CHK;
            rau_pkg::ST_RED_NUM: if (!i_sts.div_busy) n_state = rau_pkg::ST_RED_DEN;
            rau_pkg::ST_RED_DEN: if (!i_sts.div_busy) n_state = rau_pkg::ST_DONE;
            rau_pkg::ST_DONE:    if (w_free) n_state = rau_pkg::ST_IDLE;
            default:             n_state = rau_pkg::ST_IDLE;
        endcase
    end

    // division is started on entry to each divide state, ended by !busy
    always_comb begin
        o_cmd = '0;
        n_ov = r_ov && !i_out_ready;
        o_in_ready = 1'b0;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rau_pkg::ST_MUL1: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.mul_sel  = 2'd0;
            end
            rau_pkg::ST_MUL2: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.mul_sel  = 2'd2;
            end
            rau_pkg::ST_MUL3: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.mul_sel  = 2'd3;
            end
            rau_pkg::ST_SUM: o_cmd.sum = 1'b1;
            rau_pkg::ST_GCD_CHK: begin
                o_cmd.div_mode = i_sts.b_zero ? rau_pkg::DM_NUM : rau_pkg::DM_GCD;
                o_cmd.div_start = !(i_sts.b_zero && i_sts.a_zero);
            end
            rau_pkg::ST_GCD_DIV: begin
                o_cmd.gcd_swap = !i_sts.div_busy;
            end
            rau_pkg::ST_RED_NUM: begin
                o_cmd.red_num   = !i_sts.div_busy;
                o_cmd.div_mode  = rau_pkg::DM_DEN;
                o_cmd.div_start = !i_sts.div_busy;
            end
            rau_pkg::ST_RED_DEN: o_cmd.red_den = !i_sts.div_busy;
            rau_pkg::ST_DONE: begin
                if (w_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ov = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_out_valid = r_ov;
endmodule
`default_nettype wire

FILE: design/rational_arithmetic_unit.sv
`default_nettype none
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   left_num, left_den, right_num, right_den    req_type
// m_axis    out  result_numerator, result_denominator        zero_denominator
//
// Multiply and divide pass from one accepted word to the next ready through
// accept, two multiplies and output load. Add and subtract pass through accept,
// three multiplies, the sum, each Euclidean remainder step, the two divisions
// of the reduction and output load; their time is set by the one bit-serial
// divider that all remainders and quotients share. Reset (synchronous, active
// low) empties the controller and the output word. A result waits in the
// output register while the next word is accepted and worked on; the unit
// stalls only when a finished result meets a still-held one.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // left_num, left_den, right_num, right_den
    input  wire logic [1:0]   s_axis_tuser,  // req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // result_numerator, result_denominator
    output logic              m_axis_tuser   // zero_denominator
);
    rau_pkg::t_cmd w_cmd;
    rau_pkg::t_sts w_sts;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_op   (s_axis_tuser),
        .i_ln   (s_axis_tdata[31:0]),
        .i_ld   (s_axis_tdata[63:32]),
        .i_rn   (s_axis_tdata[95:64]),
        .i_rd   (s_axis_tdata[127:96]),
        .o_sts  (w_sts),
        .o_num  (m_axis_tdata[31:0]),
        .o_den  (m_axis_tdata[63:32]),
        .o_zero (m_axis_tuser)
    );

    // flag must agree with the held denominator
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[63:32] == 32'd0)))
        else $error("zero flag mismatch");
    // no new word taken while one is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted");
    // a load into the output never drops a waiting word
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && m_axis_tvalid) |-> m_axis_tready)
        else $error("result overwritten");
endmodule
`default_nettype wire

FILE: tb/rational_arithmetic_unit_test.sv
`default_nettype none
module rational_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;

    typedef struct packed {
        logic [31:0] rden;
        logic [31:0] rnum;
        logic [31:0] lden;
        logic [31:0] lnum;
    } t_operands;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
        logic        zden;
    } t_fraction;

    // One row of the directed table; has_exp marks a hand-typed answer.
    typedef struct {
        rau_pkg::t_op op;
        logic [31:0]  ln, ld, rn, rd;
        bit           has_exp;
        logic [31:0]  en, ed;
        logic         ez;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // left_num, left_den, right_num, right_den
    logic [1:0]   s_axis_tuser;   // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // result_numerator, result_denominator
    logic         m_axis_tuser;   // zero_denominator

    rational_arithmetic_unit #(.WORD_BITS(W)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_fraction pending_fractions[$];
    int        fail_count = 0;
    int        sent_count = 0;
    bit        stim_done = 0;
    bit        hold_sink = 0;   // long backpressure stretch, owned by the hold process

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Magnitude of a 32-bit two's-complement word.
    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    // Truncating remainder; sign follows the dividend.
    function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        r = mag32(a) % mag32(b);
        return a[31] ? -r : r;
    endfunction

    // Truncating quotient; most-negative by -1 wraps.
    function automatic logic [31:0] trunc_quo(logic [31:0] a, logic [31:0] b);
        logic [31:0] q;
        q = mag32(a) / mag32(b);
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Combine two fractions; add/sub reduce by a signed Euclidean GCD.
    function automatic t_fraction combine_fractions(rau_pkg::t_op op, t_operands x);
        t_fraction   f;
        logic [31:0] p, q, a, b, t;
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                p = x.lnum * x.rden;
                q = x.rnum * x.lden;
                f.num = (op == rau_pkg::OP_ADD) ? p + q : p - q;
                f.den = x.lden * x.rden;
                a = f.num;
                b = f.den;
                while (b != 0) begin
                    t = b;
                    b = trunc_rem(a, b);
                    a = t;
                end
                if (a != 0) begin
                    f.num = trunc_quo(f.num, a);
                    f.den = trunc_quo(f.den, a);
                end
            end
            rau_pkg::OP_MUL: begin
                f.num = x.lnum * x.rnum;
                f.den = x.lden * x.rden;
            end
            default: begin
                f.num = x.lnum * x.rden;
                f.den = x.lden * x.rnum;
            end
        endcase
        f.zden = (f.den == 0);
        return f;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Offer one word and hold it until accepted; queue the expectation.
    // Return at the accepting edge with tvalid still high.
    task automatic send_word(rau_pkg::t_op op, t_operands x, t_fraction f);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= op;
        pending_fractions.push_back(f);
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        @(posedge i_clk);
        sent_count++;
    endtask

    // For a nonzero gap, drop tvalid after an accepted word and idle through it.
    task automatic idle_gap(int len);
        if (len > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Sink: random stalls, plus a long hold when the hold process asks for one.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    // Checker: compare each accepted word with the oldest expectation.
    // Sample between edges, where the handshake for the next edge is settled.
    always @(negedge i_clk) begin
        t_fraction e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_fractions.size() == 0) begin
                $display("%0t: unexpected result %h/%h", $realtime, m_axis_tdata[31:0],
                         m_axis_tdata[63:32]);
                fail_count++;
            end else begin
                e = pending_fractions.pop_front();
                if (m_axis_tdata[31:0] !== e.num) begin
                    $display("%0t: numerator expected %h actual %h", $realtime, e.num,
                             m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== e.den) begin
                    $display("%0t: denominator expected %h actual %h", $realtime, e.den,
                             m_axis_tdata[63:32]);
                    fail_count++;
                end
                if (m_axis_tuser !== e.zden) begin
                    $display("%0t: zero flag expected %b actual %b", $realtime, e.zden,
                             m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Random operand: mostly small, sometimes extreme, sometimes any 32-bit pattern.
    function automatic logic [31:0] rand_operand(bit nonzero);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom();
            1:       v = $urandom_range(0, 3) == 0 ? MINN : ($urandom_range(0, 1) ? MAXP : NEG1);
            2:       v = $urandom_range(0, 1) ? 0 : 1;
            default: v = $urandom_range(0, 2000) - 1000;
        endcase
        if (nonzero && v == 0 && $urandom_range(0, 7) != 0) v = 1;
        return v;
    endfunction

    initial begin
        t_row          rows[$];
        t_operands     x;
        t_fraction     f;
        rau_pkg::t_op  op;
        int            guard;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rau_pkg::OP_ADD;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hand-checked extremes and zero-denominator cases; others use the predictor.
        rows = '{
            '{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1, 32'd5, 32'd6, 1'b0},
            '{rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1, 32'd0, 32'd1, 1'b0},
            '{rau_pkg::OP_MUL, 32'd3, 32'd4, 32'd5, 32'd7, 1, 32'd15, 32'd28, 1'b0},
            '{rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd5, 32'd7, 1, 32'd21, 32'd20, 1'b0},
            '{rau_pkg::OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1, 32'd0, 32'd0, 1'b1},
            '{rau_pkg::OP_ADD, 32'd5, 32'd1, 32'd3, 32'd0, 1, 32'd1, 32'd0, 1'b1},
            '{rau_pkg::OP_MUL, 32'd5, 32'd0, 32'd3, 32'd4, 1, 32'd15, 32'd0, 1'b1},
            '{rau_pkg::OP_DIV, 32'd5, 32'd2, 32'd0, 32'd4, 1, 32'd20, 32'd0, 1'b1},
            '{rau_pkg::OP_MUL, MINN, 32'd1, NEG1, 32'd1, 1, MINN, 32'd1, 1'b0},
            '{rau_pkg::OP_MUL, MAXP, MAXP, MAXP, MAXP, 1, 32'd1, 32'd1, 1'b0},
            '{rau_pkg::OP_ADD, MINN, 32'd1, 32'd0, NEG1, 0, 0, 0, 0},
            '{rau_pkg::OP_SUB, MINN, NEG1, MAXP, MINN, 0, 0, 0, 0},
            '{rau_pkg::OP_ADD, MAXP, MAXP, MAXP, MAXP, 0, 0, 0, 0},
            '{rau_pkg::OP_SUB, NEG1, 32'd3, 32'd2, NEG1, 0, 0, 0, 0},
            '{rau_pkg::OP_ADD, 32'd6, NEG1, 32'd4, 32'hFFFF_FFFE, 0, 0, 0, 0},
            '{rau_pkg::OP_DIV, MINN, NEG1, NEG1, MINN, 0, 0, 0, 0},
            '{rau_pkg::OP_SUB, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321,
              0, 0, 0, 0},
            '{rau_pkg::OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
              0, 0, 0, 0}
        };
        foreach (rows[i]) begin
            x = '{rden: rows[i].rd, rnum: rows[i].rn, lden: rows[i].ld, lnum: rows[i].ln};
            if (rows[i].has_exp) f = '{num: rows[i].en, den: rows[i].ed, zden: rows[i].ez};
            else f = combine_fractions(rows[i].op, x);
            send_word(rows[i].op, x, f);
        end

        for (int n = 0; n < 370; n++) begin
            // Drain pause: wait for every expected word before going on.
            if (n == 250) begin
                s_axis_tvalid <= 1'b0;
                guard = 0;
                while (pending_fractions.size() != 0 && guard < 200000) begin
                    @(posedge i_clk);
                    guard++;
                end
                @(posedge i_clk);
            end
            op = rau_pkg::t_op'($urandom_range(0, 3));
            x.lnum = rand_operand(0);
            x.lden = rand_operand(1);
            x.rnum = rand_operand(0);
            x.rden = rand_operand(1);
            send_word(op, x, combine_fractions(op, x));
            if (n < 100 || n > 200) idle_gap(gap_len());
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Long sink hold, counted in cycles here while the sender keeps offering
    // words back to back, so the unit fills and stalls its input.
    initial begin
        wait (sent_count >= 138);
        hold_sink <= 1'b1;
        repeat (8000) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    initial begin
        wait (stim_done);
        while (pending_fractions.size() != 0) @(posedge i_clk);
        repeat (1700) @(posedge i_clk);
        if (fail_count == 0) $display("rational_arithmetic_unit test passed");
        else $display("rational_arithmetic_unit test failed");
        $finish;
    end

    // Watchdog: 388 words at the longest add/subtract time plus stalls, several times over.
    initial begin
        #(12ns * 4_000_000);
        $display("rational_arithmetic_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/rau_pkg.sv
design/rau_divider.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
